[hw/rtl/haptic_torque_regulator_defines.svh]
// Assertion macros shared by the checkers of the haptic torque regulator.
// Depends on nothing; included by the checker file.
`ifndef HAPTIC_TORQUE_REGULATOR_DEFINES_SVH
`define HAPTIC_TORQUE_REGULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hw/rtl/htr_pkg.sv]
// Package of the haptic torque regulator: register indexes, reset values,
// microcode operations, conditions and the control store. Depends on nothing.
`timescale 1ns / 1ps
package htr_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned StepW = 3;

  localparam logic [CfgIdxW-1:0] REG_WALL_ANGLE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_FAR_ANGLE = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WALL_TORQUE = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SETTLE_LIMIT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPAN_RECIP = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_STEP_GAIN = 3'd5;

  localparam logic signed [15:0] RST_WALL_ANGLE = 16'sd720;
  localparam logic signed [15:0] RST_FAR_ANGLE = 16'sd1440;
  localparam logic signed [17:0] RST_WALL_TORQUE = -18'sd32768;
  localparam logic [15:0] RST_SETTLE_LIMIT = 16'd20;
  localparam logic [23:0] RST_SPAN_RECIP = 24'd808541;
  localparam logic [15:0] RST_STEP_GAIN = 16'd328;

  localparam logic signed [17:0] Q_ONE = 18'sd65536;

  localparam logic [1:0] ZONE_GREEN = 2'd0;
  localparam logic [1:0] ZONE_BLUE = 2'd1;
  localparam logic [1:0] ZONE_RED = 2'd2;

  localparam logic [2:0] OP_NOP = 3'd0;
  localparam logic [2:0] OP_LATCH = 3'd1;
  localparam logic [2:0] OP_MUL_MEAS = 3'd2;
  localparam logic [2:0] OP_MUL_GAIN = 3'd3;
  localparam logic [2:0] OP_ACCUM = 3'd4;
  localparam logic [2:0] OP_CALIB = 3'd5;
  localparam logic [2:0] OP_EMIT = 3'd6;

  localparam logic [2:0] CND_NEVER = 3'd0;
  localparam logic [2:0] CND_ALWAYS = 3'd1;
  localparam logic [2:0] CND_NO_INPUT = 3'd2;
  localparam logic [2:0] CND_CALIBRATING = 3'd3;
  localparam logic [2:0] CND_OUT_BUSY = 3'd4;

  typedef struct packed {
    logic [2:0]       op;
    logic [2:0]       cond;
    logic [StepW-1:0] target;
  } htr_ctrl_t;

  function automatic htr_ctrl_t htr_rom(input logic [StepW-1:0] step);
    htr_ctrl_t w;
    unique case (step)
      3'd0:    w = '{op: OP_LATCH, cond: CND_NO_INPUT, target: 3'd0};
      3'd1:    w = '{op: OP_NOP, cond: CND_CALIBRATING, target: 3'd6};
      3'd2:    w = '{op: OP_MUL_MEAS, cond: CND_NEVER, target: 3'd0};
      3'd3:    w = '{op: OP_MUL_GAIN, cond: CND_NEVER, target: 3'd0};
      3'd4:    w = '{op: OP_ACCUM, cond: CND_ALWAYS, target: 3'd7};
      3'd5:    w = '{op: OP_NOP, cond: CND_ALWAYS, target: 3'd0};
      3'd6:    w = '{op: OP_CALIB, cond: CND_NEVER, target: 3'd0};
      default: w = '{op: OP_EMIT, cond: CND_OUT_BUSY, target: 3'd7};
    endcase
    return w;
  endfunction

endpackage

[hw/rtl/haptic_torque_regulator.sv]
// Haptic torque regulator top level: microcoded sequencer with one shared
// 26 x 17 multiplier, calibration logic and an output register. Uses htr_pkg.
// Steps: latch, then calibrate or multiply twice and accumulate, then emit the result.
// No new transaction is accepted until the previous result is in the output register,
// and the input stalls while a result waits; the control program shares one multiplier.
// Reset: asynchronous, active low; clears state and the program step, reloads configuration.
`timescale 1ns / 1ps
module haptic_torque_regulator import htr_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [CfgIdxW-1:0]         cfg_index_i,
  input  logic [CfgDataW-1:0]        cfg_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [15:0]         position_i,
  input  logic signed [15:0]         torque_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       calibrated_o,
  output logic signed [17:0]         duty_o,
  output logic [16:0]                pwm_positive_o,
  output logic [16:0]                pwm_negative_o,
  output logic [1:0]                 zone_o
);

  logic signed [15:0] wall_angle_q, far_angle_q;
  logic signed [17:0] wall_torque_q;
  logic [15:0]        settle_limit_q, step_gain_q;
  logic [23:0]        span_recip_q;

  logic [StepW-1:0]   step_q, step_d;
  htr_ctrl_t          ctrl;
  logic               jump;
  logic               in_accept, out_busy;

  logic               cal_q, cal_d, first_q, first_d;
  logic signed [15:0] prev_q, prev_d, zero_q, zero_d;
  logic signed [17:0] acc_q, acc_d;
  logic signed [15:0] pos_q, sample_q;
  logic signed [42:0] prod_q;
  logic               out_valid_q;

  logic signed [25:0] mul_a, err;
  logic signed [16:0] mul_b, diff_zero, diff_prev;
  logic [16:0]        abs_prev;
  logic signed [42:0] mul_p;
  logic signed [17:0] wall_clamped, desired, acc_next;
  logic signed [27:0] acc_sum;
  logic [1:0]         zone;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_angle_q   <= RST_WALL_ANGLE;
      far_angle_q    <= RST_FAR_ANGLE;
      wall_torque_q  <= RST_WALL_TORQUE;
      settle_limit_q <= RST_SETTLE_LIMIT;
      span_recip_q   <= RST_SPAN_RECIP;
      step_gain_q    <= RST_STEP_GAIN;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_WALL_ANGLE:   wall_angle_q   <= cfg_data_i[15:0];
        REG_FAR_ANGLE:    far_angle_q    <= cfg_data_i[15:0];
        REG_WALL_TORQUE:  wall_torque_q  <= cfg_data_i[17:0];
        REG_SETTLE_LIMIT: settle_limit_q <= cfg_data_i[15:0];
        REG_SPAN_RECIP:   span_recip_q   <= cfg_data_i[23:0];
        REG_STEP_GAIN:    step_gain_q    <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign ctrl       = htr_rom(step_q);
  assign in_stall_o = (step_q != '0);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_busy   = out_valid_q && out_stall_i;

  always_comb begin
    unique case (ctrl.cond)
      CND_NEVER:       jump = 1'b0;
      CND_ALWAYS:      jump = 1'b1;
      CND_NO_INPUT:    jump = !in_accept;
      CND_CALIBRATING: jump = !cal_q;
      CND_OUT_BUSY:    jump = out_busy;
      default:         jump = 1'b0;
    endcase
    step_d = jump ? ctrl.target : step_q + StepW'(1);
  end

  assign wall_clamped = (wall_torque_q > Q_ONE) ? Q_ONE :
                        (wall_torque_q < -Q_ONE) ? -Q_ONE : wall_torque_q;
  assign desired      = (pos_q > wall_angle_q) ? wall_clamped : '0;
  assign zone         = (pos_q > far_angle_q) ? ZONE_RED :
                        (pos_q > wall_angle_q) ? ZONE_BLUE : ZONE_GREEN;

  assign diff_zero = 17'(sample_q) - 17'(zero_q);
  assign diff_prev = 17'(sample_q) - 17'(prev_q);
  assign abs_prev  = diff_prev[16] ? 17'(-diff_prev) : 17'(diff_prev);
  assign err       = 26'(desired) - prod_q[41:16];

  always_comb begin
    if (ctrl.op == OP_MUL_GAIN) begin
      mul_a = err;
      mul_b = $signed({1'b0, step_gain_q});
    end else begin
      mul_a = $signed({2'b00, span_recip_q});
      mul_b = diff_zero;
    end
  end

  assign mul_p = 43'(mul_a) * 43'(mul_b);

  assign acc_sum  = 28'(acc_q) + 28'($signed(prod_q[42:16]));
  assign acc_next = (acc_sum > 28'(Q_ONE)) ? Q_ONE :
                    (acc_sum < -28'(Q_ONE)) ? -Q_ONE : acc_sum[17:0];

  always_comb begin
    cal_d   = cal_q;
    first_d = first_q;
    prev_d  = prev_q;
    zero_d  = zero_q;
    acc_d   = acc_q;
    unique case (ctrl.op)
      OP_ACCUM: acc_d = acc_next;
      OP_CALIB: begin
        prev_d = sample_q;
        if (!first_q) begin
          first_d = 1'b1;
        end else if (abs_prev < {1'b0, settle_limit_q}) begin
          zero_d = sample_q;
          cal_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      cal_q       <= 1'b0;
      first_q     <= 1'b0;
      prev_q      <= '0;
      zero_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      cal_q   <= cal_d;
      first_q <= first_d;
      prev_q  <= prev_d;
      zero_q  <= zero_d;
      acc_q   <= acc_d;
      if (ctrl.op == OP_EMIT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pos_q    <= position_i;
      sample_q <= torque_sample_i;
    end
    if (ctrl.op == OP_MUL_MEAS || ctrl.op == OP_MUL_GAIN) begin
      prod_q <= mul_p;
    end
    if (ctrl.op == OP_EMIT && !out_busy) begin
      calibrated_o   <= cal_q;
      duty_o         <= acc_q;
      pwm_positive_o <= (acc_q > 18'sd0) ? acc_q[16:0] : '0;
      pwm_negative_o <= (acc_q < 18'sd0) ? 17'(-acc_q) : '0;
      zone_o         <= cal_q ? zone : ZONE_GREEN;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[hw/rtl/htr_checker.sv]
// Port-level checker of the haptic torque regulator and its bind statement.
// Uses the macros of haptic_torque_regulator_defines.svh.
`timescale 1ns / 1ps
`include "haptic_torque_regulator_defines.svh"
module htr_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic               calibrated_o,
  input logic signed [17:0] duty_o,
  input logic [16:0]        pwm_positive_o,
  input logic [16:0]        pwm_negative_o,
  input logic [1:0]         zone_o
);

  // A stalled transaction stays offered.
  `HTR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  // Only one driver is ever given a non-zero duty.
  `HTR_ASSERT_NOW(a_pwm_excl, clk_i, rst_ni, out_valid_o, pwm_positive_o == 17'd0 || pwm_negative_o == 17'd0)
  // While calibrating the loop is idle and the zone reads green.
  `HTR_ASSERT_NOW(a_cal_idle, clk_i, rst_ni, out_valid_o && !calibrated_o, duty_o == 18'sd0 && zone_o == 2'd0)
  // The duty stays saturated within plus and minus one.
  `HTR_ASSERT_NOW(a_duty_sat, clk_i, rst_ni, out_valid_o, duty_o <= 18'sd65536 && duty_o >= -18'sd65536)

endmodule

bind haptic_torque_regulator htr_checker u_htr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .calibrated_o   (calibrated_o),
  .duty_o         (duty_o),
  .pwm_positive_o (pwm_positive_o),
  .pwm_negative_o (pwm_negative_o),
  .zone_o         (zone_o)
);

[bench/haptic_torque_regulator_checker.sv]
// Checker for the haptic torque regulator: watches the configuration port and both
// channels, predicts every result of the calibration and wall-law loop, and compares.
// Depends on htr_pkg for register indexes, reset values and zone codes.
`timescale 1ns / 1ps
module haptic_torque_regulator_checker import htr_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic signed [15:0]  position_i,
  input  logic signed [15:0]  torque_sample_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic                calibrated_i,
  input  logic signed [17:0]  duty_i,
  input  logic [16:0]         pwm_positive_i,
  input  logic [16:0]         pwm_negative_i,
  input  logic [1:0]          zone_i,
  output int unsigned         mismatch_count_o,
  output int unsigned         pending_count_o,
  output int unsigned         checked_count_o
);

  typedef struct packed {
    logic               calibrated;
    logic signed [17:0] duty;
    logic [16:0]        pwm_positive;
    logic [16:0]        pwm_negative;
    logic [1:0]         zone;
  } torque_result_t;

  logic signed [15:0] wall_angle_q;
  logic signed [15:0] far_angle_q;
  logic signed [17:0] wall_torque_q;
  logic [15:0]        settle_limit_q;
  logic [23:0]        span_recip_q;
  logic [15:0]        step_gain_q;

  bit                 calibrated_q;
  bit                 have_first_q;
  logic signed [15:0] prev_sample_q;
  logic signed [15:0] torque_zero_q;
  logic signed [17:0] duty_q;

  torque_result_t duty_expected[$];
  torque_result_t oldest;
  int unsigned    mismatches;
  int unsigned    checked;

  function automatic longint clamp_unit(input longint v);
    if (v > 65536) return 65536;
    if (v < -65536) return -65536;
    return v;
  endfunction

  function automatic logic [1:0] zone_of(input logic signed [15:0] pos);
    if (pos > far_angle_q) return ZONE_RED;
    if (pos > wall_angle_q) return ZONE_BLUE;
    return ZONE_GREEN;
  endfunction

  function automatic torque_result_t regulate(input logic signed [15:0] pos,
                                              input logic signed [15:0] raw);
    longint sample_diff;
    longint desired;
    longint measured;
    longint step;
    torque_result_t r;
    r.zone = ZONE_GREEN;
    if (!calibrated_q) begin
      if (!have_first_q) begin
        have_first_q = 1'b1;
      end else begin
        sample_diff = longint'(raw) - longint'(prev_sample_q);
        if (sample_diff < 0) sample_diff = -sample_diff;
        if (sample_diff < longint'(settle_limit_q)) begin
          torque_zero_q = raw;
          calibrated_q = 1'b1;
        end
      end
      prev_sample_q = raw;
      if (calibrated_q) r.zone = zone_of(pos);
    end else begin
      desired = 0;
      if (pos > wall_angle_q) desired = clamp_unit(longint'(wall_torque_q));
      measured = ((longint'(raw) - longint'(torque_zero_q)) * longint'(span_recip_q)) >>> 16;
      step = (longint'(step_gain_q) * (desired - measured)) >>> 16;
      duty_q = 18'(clamp_unit(longint'(duty_q) + step));
      r.zone = zone_of(pos);
    end
    r.calibrated = calibrated_q;
    r.duty = duty_q;
    r.pwm_positive = (duty_q > 0) ? 17'(longint'(duty_q)) : 17'd0;
    r.pwm_negative = (duty_q < 0) ? 17'(-longint'(duty_q)) : 17'd0;
    return r;
  endfunction

  function automatic void note_failure(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  function automatic void compare_field(input string field, input longint want,
                                        input longint got);
    if (want != got)
      note_failure($sformatf("result %0d, %s: expected %0d, got %0d",
                             checked, field, want, got));
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_angle_q = RST_WALL_ANGLE;
      far_angle_q = RST_FAR_ANGLE;
      wall_torque_q = RST_WALL_TORQUE;
      settle_limit_q = RST_SETTLE_LIMIT;
      span_recip_q = RST_SPAN_RECIP;
      step_gain_q = RST_STEP_GAIN;
      calibrated_q = 1'b0;
      have_first_q = 1'b0;
      prev_sample_q = '0;
      torque_zero_q = '0;
      duty_q = '0;
      duty_expected.delete();
      mismatches = 0;
      checked = 0;
      mismatch_count_o <= 0;
      pending_count_o <= 0;
      checked_count_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (duty_expected.size() == 0) begin
          note_failure("result transaction with no expected result waiting");
        end else begin
          oldest = duty_expected.pop_front();
          compare_field("calibrated", longint'(oldest.calibrated), longint'(calibrated_i));
          compare_field("duty", longint'(oldest.duty), longint'(duty_i));
          compare_field("pwm_positive", longint'(oldest.pwm_positive),
                        longint'(pwm_positive_i));
          compare_field("pwm_negative", longint'(oldest.pwm_negative),
                        longint'(pwm_negative_i));
          compare_field("zone", longint'(oldest.zone), longint'(zone_i));
          checked++;
        end
      end
      if (in_valid_i && !in_stall_i)
        duty_expected.push_back(regulate(position_i, torque_sample_i));
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_WALL_ANGLE:   wall_angle_q = cfg_data_i[15:0];
          REG_FAR_ANGLE:    far_angle_q = cfg_data_i[15:0];
          REG_WALL_TORQUE:  wall_torque_q = cfg_data_i[17:0];
          REG_SETTLE_LIMIT: settle_limit_q = cfg_data_i[15:0];
          REG_SPAN_RECIP:   span_recip_q = cfg_data_i[23:0];
          REG_STEP_GAIN:    step_gain_q = cfg_data_i[15:0];
          default: ;
        endcase
      end
      mismatch_count_o <= mismatches;
      pending_count_o <= duty_expected.size();
      checked_count_o <= checked;
    end
  end

endmodule

[bench/haptic_torque_regulator_test.sv]
// Top of the haptic torque regulator testbench: clock, reset, configuration writes,
// directed and random stimulus under varied idling, and the verdict.
// Depends on htr_pkg, haptic_torque_regulator and haptic_torque_regulator_checker.
`timescale 1ns / 1ps
module haptic_torque_regulator_test import htr_pkg::*; ();

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned ItemsPerPhase = 150;
  localparam int TorqueZero = -11;
  localparam logic [CfgIdxW-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_SPARE_B = 3'd7;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic signed [15:0]  position;
  logic signed [15:0]  torque_sample;
  logic                out_valid;
  logic                out_stall;
  logic                calibrated;
  logic signed [17:0]  duty;
  logic [16:0]         pwm_positive;
  logic [16:0]         pwm_negative;
  logic [1:0]          zone;

  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;
  int unsigned sent_count = 0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_left = 0;
  logic signed [15:0] wall_now = RST_WALL_ANGLE;
  logic signed [15:0] far_now = RST_FAR_ANGLE;

  always #5 clk = ~clk;

  haptic_torque_regulator dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .position_i      (position),
    .torque_sample_i (torque_sample),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .calibrated_o    (calibrated),
    .duty_o          (duty),
    .pwm_positive_o  (pwm_positive),
    .pwm_negative_o  (pwm_negative),
    .zone_o          (zone)
  );

  haptic_torque_regulator_checker regulator_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_we_i         (cfg_we),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .position_i       (position),
    .torque_sample_i  (torque_sample),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .calibrated_i     (calibrated),
    .duty_i           (duty),
    .pwm_positive_i   (pwm_positive),
    .pwm_negative_i   (pwm_negative),
    .zone_i           (zone),
    .mismatch_count_o (mismatch_count),
    .pending_count_o  (pending_count),
    .checked_count_o  (checked_count)
  );

  task automatic offer(input logic signed [15:0] pos, input logic signed [15:0] raw);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    position <= pos;
    torque_sample <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic settle_down();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CfgDataW'(value);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_setting(input bit reset_values);
    int wall;
    int far_a;
    int torque;
    int settle;
    int span;
    int gain;
    if (reset_values) begin
      wall = RST_WALL_ANGLE;
      far_a = RST_FAR_ANGLE;
      torque = RST_WALL_TORQUE;
      settle = RST_SETTLE_LIMIT;
      span = RST_SPAN_RECIP;
      gain = RST_STEP_GAIN;
    end else begin
      wall = int'($urandom_range(4000)) - 2000;
      far_a = wall + int'($urandom_range(2000));
      torque = int'($urandom_range(131072)) - 65536;
      settle = $urandom_range(65535);
      span = $urandom_range(1 << 21);
      gain = $urandom_range(4000);
    end
    wall_now = 16'(wall);
    far_now = 16'(far_a);
    write_reg(REG_WALL_ANGLE, wall);
    write_reg(REG_FAR_ANGLE, far_a);
    write_reg(REG_WALL_TORQUE, torque);
    write_reg(REG_SETTLE_LIMIT, settle);
    write_reg(REG_SPAN_RECIP, span);
    write_reg(REG_STEP_GAIN, gain);
  endtask

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    repeat (CycleLimit) @(posedge clk);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic signed [15:0] pos;
    logic signed [15:0] raw;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    position = '0;
    torque_sample = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Calibration: a zero limit can never be met, and a change of exactly the
    // limit is not yet settled.
    write_reg(REG_SETTLE_LIMIT, 0);
    offer(16'sd32767, -16'sd32768);
    offer(-16'sd32768, 16'sd32767);
    offer(16'sd0, 16'sd32767);
    settle_down();
    write_reg(REG_SETTLE_LIMIT, 65535);
    offer(16'sd1000, -16'sd32768);
    settle_down();
    write_reg(REG_SETTLE_LIMIT, RST_SETTLE_LIMIT);
    offer(16'sd2000, -16'sd12);
    offer(16'sd720, 16'sd8);
    offer(16'sd721, 16'(TorqueZero));

    offer(16'sd720, 16'(TorqueZero));
    offer(16'sd721, 16'(TorqueZero));
    offer(16'sd1441, 16'sd32767);
    offer(-16'sd32768, -16'sd32768);
    offer(16'sd32767, 16'sd32767);
    settle_down();

    // Out-of-range wall torque is clamped; large gain and span drive saturation.
    write_reg(REG_WALL_TORQUE, 131071);
    write_reg(REG_STEP_GAIN, 65535);
    write_reg(REG_SPAN_RECIP, 16777215);
    write_reg(REG_WALL_ANGLE, -32768);
    write_reg(REG_FAR_ANGLE, 32767);
    offer(16'sd0, 16'(TorqueZero));
    offer(16'sd0, 16'sd32767);
    offer(-16'sd32768, -16'sd32768);
    offer(-16'sd32767, 16'sd100);
    settle_down();

    write_reg(REG_WALL_TORQUE, -131072);
    write_reg(REG_STEP_GAIN, 0);
    write_reg(REG_SPAN_RECIP, 0);
    write_reg(REG_WALL_ANGLE, 32767);
    write_reg(REG_FAR_ANGLE, -32768);
    write_reg(REG_SPARE_A, 'h5a5a5a);
    write_reg(REG_SPARE_B, 'ha5a5a5);
    offer(16'sd32767, 16'sd5);
    offer(-16'sd32768, 16'sd5);
    settle_down();

    // A unit span shows the rounding of small negative products downwards.
    write_reg(REG_WALL_TORQUE, -65536);
    write_reg(REG_STEP_GAIN, 65535);
    write_reg(REG_SPAN_RECIP, 1);
    write_reg(REG_WALL_ANGLE, 0);
    write_reg(REG_WALL_TORQUE, 65536);
    offer(16'sd1, 16'(TorqueZero));
    offer(16'sd1, 16'(TorqueZero - 1));
    offer(16'sd0, 16'sd32767);
    settle_down();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 71; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 71; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      load_setting(phase == 0);
      if (phase == 0) begin
        @(posedge clk);
        hold_left = HoldOffCycles;
        @(negedge clk);
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        case ($urandom_range(3))
          0: pos = 16'($urandom);
          1: pos = 16'(int'(far_now) + int'($urandom_range(64)) - 32);
          default: pos = 16'(int'(wall_now) + int'($urandom_range(64)) - 32);
        endcase
        if ($urandom_range(3) == 0) raw = 16'($urandom);
        else raw = 16'(TorqueZero + int'($urandom_range(600)) - 300);
        offer(pos, raw);
      end
      settle_down();
    end

    $display("Sent %0d transactions and checked %0d results: calibration limits, wall law,",
             sent_count, checked_count);
    $display("saturation and clamping, four idling mixes and one long output hold-off.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
